/* hdl/fpp_pkg.sv */
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and record codes for the fast-path input PDU parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

    // Record kinds on the result channel
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_SYNC     = 3'd1;
    localparam logic [2:0] KIND_SCAN     = 3'd2;
    localparam logic [2:0] KIND_MOUSE    = 3'd3;
    localparam logic [2:0] KIND_MOUSEX   = 3'd4;
    localparam logic [2:0] KIND_UNICODE  = 3'd5;
    localparam logic [2:0] KIND_TRUNC    = 3'd6;
    localparam logic [2:0] KIND_BADFLAGS = 3'd7;

    // One result record
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic [15:0] flag_word;
    } rec_t;

endpackage

/* hdl/fpp_chan_if.sv */
// ----------------------------------------------------------------------------
// fpp_in_if / fpp_out_if
// Valid/ready channels for PDU bytes in and parsed records out.
// ----------------------------------------------------------------------------
interface fpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [15:0] flag_word;

    modport source (output valid, output record_kind, output first_value,
                    output second_value, output flag_word, input ready);
    modport sink   (input valid, input record_kind, input first_value,
                    input second_value, input flag_word, output ready);
endinterface

/* hdl/fastpath_input_pdu_parser_top.sv */
// ----------------------------------------------------------------------------
// fastpath_input_pdu_parser_top
// Fast-path input PDU parser: one PDU byte in per transaction, records out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_chan.ready is high, with
// last_byte marking the final byte of a PDU. Each byte is decoded in the cycle
// it is accepted and its record, if any, is registered into the result register
// that drives the output channel. A second result register (skid entry) absorbs
// one record while the output side stalls, so in_chan.ready drops only when both
// hold a record; it is a registered signal and does not depend on out_chan.ready
// in the same cycle. Records come out in byte order: a header record once the
// length is complete, one record per completed sync, scan, mouse or unicode event,
// and a truncated or bad-flags record where the PDU is malformed, after which
// bytes are dropped until the final byte. Any final byte returns the parser to
// the start of a new PDU.
// ----------------------------------------------------------------------------
module fastpath_input_pdu_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    fpp_in_if.sink     in_chan,
    fpp_out_if.source  out_chan
);

    logic          take;
    logic          space;
    logic          rec_valid;
    fpp_pkg::rec_t rec;
    fpp_pkg::rec_t out_rec;

    // Accept a byte whenever the skid entry is free
    assign in_chan.ready = space;
    assign take          = in_chan.valid & space;

    fpp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (in_chan.data_byte),
        .last_byte (in_chan.last_byte),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Push only records that belong to an accepted byte
    fpp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take & rec_valid),
        .push_rec  (rec),
        .space     (space),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .out_rec   (out_rec)
    );

    assign out_chan.record_kind  = out_rec.record_kind;
    assign out_chan.first_value  = out_rec.first_value;
    assign out_chan.second_value = out_rec.second_value;
    assign out_chan.flag_word    = out_rec.flag_word;

endmodule

/* hdl/fpp_parse.sv */
// ----------------------------------------------------------------------------
// fpp_parse
// Parser state and per-byte decode; produces at most one record per byte.
// ----------------------------------------------------------------------------
module fpp_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output logic          rec_valid,
    output fpp_pkg::rec_t rec
);

    localparam logic [2:0] PH_HDR     = 3'd0;
    localparam logic [2:0] PH_LEN1    = 3'd1;
    localparam logic [2:0] PH_LEN2    = 3'd2;
    localparam logic [2:0] PH_EVHDR   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_IDLE    = 3'd5;

    localparam logic [2:0] EV_SCAN    = 3'd0;
    localparam logic [2:0] EV_MOUSE   = 3'd1;
    localparam logic [2:0] EV_MOUSEX  = 3'd2;
    localparam logic [2:0] EV_SYNC    = 3'd3;
    localparam logic [2:0] EV_UNICODE = 3'd4;

    function automatic logic [2:0] payload_need(input logic [2:0] code);
        logic [2:0] n;
        begin
            unique case (code)
                EV_SCAN:              n = 3'd1;
                EV_MOUSE, EV_MOUSEX:  n = 3'd6;
                EV_UNICODE:           n = 3'd2;
                default:              n = 3'd0;
            endcase
            return n;
        end
    endfunction

    // Map event flags to slow-path keyboard flags
    function automatic logic [15:0] kbd_flags(input logic [4:0] fl);
        logic [15:0] r;
        begin
            r = 16'h0000;
            if (fl[0]) r = r | 16'hC000;
            if (fl[1]) r = r | 16'h0100;
            if (fl[2]) r = r | 16'h0200;
            return r;
        end
    endfunction

    logic [2:0]  phase_reg,  phase_next;
    logic [3:0]  events_reg, events_next;
    logic [2:0]  code_reg,   code_next;
    logic [4:0]  flags_reg,  flags_next;
    logic [2:0]  count_reg,  count_next;
    logic [47:0] shift_reg,  shift_next;
    logic [14:0] hold_reg,   hold_next;

    logic [2:0]  ev_code;
    logic [4:0]  ev_flags;
    logic [3:0]  events_dec;
    logic [2:0]  cnt_inc;
    logic [2:0]  need_held;
    logic [47:0] shift_ins;
    logic [14:0] hdr_len;

    always_comb
    begin
        ev_code    = data_byte[7:5];
        ev_flags   = data_byte[4:0];
        events_dec = (events_reg != 4'd0) ? events_reg - 4'd1 : 4'd0;
        cnt_inc    = count_reg + 3'd1;
        need_held  = payload_need(code_reg);
        hdr_len    = (phase_reg == PH_LEN2) ? {hold_reg[14:8], data_byte}
                                            : {7'b0, data_byte};
        for (int i = 0; i < 6; i++)
        begin
            shift_ins[i*8 +: 8] = shift_reg[i*8 +: 8]
                                | ((count_reg == 3'(i)) ? data_byte : 8'h00);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        events_next = events_reg;
        code_next   = code_reg;
        flags_next  = flags_reg;
        count_next  = count_reg;
        shift_next  = shift_reg;
        hold_next   = hold_reg;
        rec_valid   = 1'b0;
        rec         = '0;

        unique case (phase_reg)
            PH_HDR:
            begin
                hold_next = {7'b0, data_byte};
                if (last_byte)
                begin
                    rec_valid       = 1'b1;
                    rec.record_kind = fpp_pkg::KIND_TRUNC;
                end
                else
                begin
                    phase_next = PH_LEN1;
                end
            end
            PH_LEN1, PH_LEN2:
            begin
                if (phase_reg == PH_LEN1 && data_byte[7])
                begin
                    hold_next = {data_byte[6:0], hold_reg[7:0]};
                    if (last_byte)
                    begin
                        rec_valid       = 1'b1;
                        rec.record_kind = fpp_pkg::KIND_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_LEN2;
                    end
                end
                else
                begin
                    // Length complete: emit the header record
                    events_next      = hold_reg[5:2];
                    phase_next       = (hold_reg[5:2] != 4'd0) ? PH_EVHDR : PH_IDLE;
                    rec_valid        = 1'b1;
                    rec.record_kind  = fpp_pkg::KIND_HEADER;
                    rec.first_value  = {1'b0, hdr_len};
                    rec.second_value = {12'b0, hold_reg[5:2]};
                    rec.flag_word    = {14'b0, hold_reg[7:6]};
                end
            end
            PH_EVHDR:
            begin
                code_next  = ev_code;
                flags_next = ev_flags;
                if ((ev_code == EV_MOUSE || ev_code == EV_MOUSEX) && ev_flags != 5'd0)
                begin
                    rec_valid       = 1'b1;
                    rec.record_kind = fpp_pkg::KIND_BADFLAGS;
                    phase_next      = PH_IDLE;
                end
                else if (payload_need(ev_code) != 3'd0)
                begin
                    if (last_byte)
                    begin
                        rec_valid       = 1'b1;
                        rec.record_kind = fpp_pkg::KIND_TRUNC;
                    end
                    else
                    begin
                        count_next = 3'd0;
                        shift_next = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    // Sync reports its toggles; unknown codes pass silently
                    if (ev_code == EV_SYNC)
                    begin
                        rec_valid       = 1'b1;
                        rec.record_kind = fpp_pkg::KIND_SYNC;
                        rec.first_value = {11'b0, ev_flags};
                    end
                    events_next = events_dec;
                    phase_next  = (events_dec != 4'd0) ? PH_EVHDR : PH_IDLE;
                end
            end
            PH_PAYLOAD:
            begin
                count_next = cnt_inc;
                shift_next = shift_ins;
                if (cnt_inc >= need_held)
                begin
                    rec_valid = 1'b1;
                    unique case (code_reg)
                        EV_SCAN:
                        begin
                            rec.record_kind = fpp_pkg::KIND_SCAN;
                            rec.first_value = {8'b0, shift_ins[7:0]};
                            rec.flag_word   = kbd_flags(flags_reg);
                        end
                        EV_MOUSE, EV_MOUSEX:
                        begin
                            rec.record_kind  = (code_reg == EV_MOUSE)
                                             ? fpp_pkg::KIND_MOUSE : fpp_pkg::KIND_MOUSEX;
                            rec.first_value  = shift_ins[31:16];
                            rec.second_value = shift_ins[47:32];
                            rec.flag_word    = shift_ins[15:0];
                        end
                        default:
                        begin
                            rec.record_kind = fpp_pkg::KIND_UNICODE;
                            rec.first_value = shift_ins[15:0];
                            rec.flag_word   = kbd_flags(flags_reg);
                        end
                    endcase
                    events_next = events_dec;
                    phase_next  = (events_dec != 4'd0) ? PH_EVHDR : PH_IDLE;
                end
                else if (last_byte)
                begin
                    rec_valid       = 1'b1;
                    rec.record_kind = fpp_pkg::KIND_TRUNC;
                end
            end
            default:
            begin
                // Parse done or stopped: drop bytes until the final one
            end
        endcase

        // The final byte returns everything to the start of a PDU
        if (last_byte)
        begin
            phase_next  = PH_HDR;
            events_next = 4'd0;
            code_next   = 3'd0;
            flags_next  = 5'd0;
            count_next  = 3'd0;
            shift_next  = '0;
            hold_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            events_reg <= 4'd0;
            code_reg   <= 3'd0;
            flags_reg  <= 5'd0;
            count_reg  <= 3'd0;
            shift_reg  <= '0;
            hold_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            events_reg <= events_next;
            code_reg   <= code_next;
            flags_reg  <= flags_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

/* hdl/fpp_obuf.sv */
// ----------------------------------------------------------------------------
// fpp_obuf
// Result register with a skid entry; decouples input ready from output ready.
// ----------------------------------------------------------------------------
module fpp_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fpp_pkg::rec_t push_rec,
    output logic          space,
    output logic          out_valid,
    input  logic          out_ready,
    output fpp_pkg::rec_t out_rec
);

    logic          out_valid_reg,  out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    fpp_pkg::rec_t out_rec_reg,    out_rec_next;
    fpp_pkg::rec_t skid_rec_reg,   skid_rec_next;
    logic          take_out;

    always_comb
    begin
        take_out        = out_valid_reg & out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_rec_next   = skid_rec_reg;
        if (skid_valid_reg)
        begin
            if (take_out)
            begin
                out_rec_next    = skid_rec_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_rec_next   = push_rec;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_rec_next   = push_rec;
                out_valid_next = 1'b1;
            end
        end
        else if (take_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

/* hdl/fpp_checker.sv */
// ----------------------------------------------------------------------------
// fpp_checker
// Port-level checks for the fast-path input PDU parser, bound to the top.
// ----------------------------------------------------------------------------
module fpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  record_kind,
    input logic [15:0] first_value,
    input logic [15:0] second_value,
    input logic [15:0] flag_word
);

    // Hold a stalled record unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_kind)
            && $stable(first_value) && $stable(second_value) && $stable(flag_word))
        else $error("stalled record changed");

    // Input backpressure only while a record waits on the output
    a_ready_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // Ready drops only after an output stall
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("ready dropped without output stall");

    // Skid entry drains when the output is taken
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_ready |=> in_ready && out_valid)
        else $error("skid entry did not drain");

    // Header records carry a 2-bit flag field and a 4-bit event count
    a_header_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == fpp_pkg::KIND_HEADER
            |-> flag_word[15:2] == 14'd0 && second_value[15:4] == 12'd0
                && first_value[15] == 1'b0)
        else $error("header record out of range");

endmodule

bind fastpath_input_pdu_parser_top fpp_checker u_fpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .record_kind  (out_chan.record_kind),
    .first_value  (out_chan.first_value),
    .second_value (out_chan.second_value),
    .flag_word    (out_chan.flag_word)
);
